[sv/pwr_pkg.sv]
// Shared types, constants and a helper function of the packet word repacker.
`default_nettype none

package pwr_pkg;

    localparam int MAX_WIDTH_BYTES = 64;
    localparam int MAX_CHUNK_WORDS = 256;
    localparam int CHUNK_LIMIT     = (MAX_CHUNK_WORDS < 256) ? MAX_CHUNK_WORDS : 256;
    localparam int MIN_WIDTH_BYTES = 4;
    localparam int GATHER_CAP      = 127;

    typedef enum logic [1:0] {
        REG_OUT_WIDTH   = 2'd0,
        REG_HEADER_HOLE = 2'd1,
        REG_FIRST_CHUNK = 2'd2,
        REG_LATER_CHUNK = 2'd3
    } pwr_reg_t;

    typedef struct packed {
        logic accept;
        logic emit;
        logic flush;
    } pwr_cmd_t;

    typedef struct packed {
        logic emit_need;
        logic more;
    } pwr_sts_t;

    // Chunk length minus one, with the length held to 1..CHUNK_LIMIT.
    function automatic logic [7:0] chunk_span(input logic [8:0] words);
        logic [8:0] c;
        c = words;
        if (c == 9'd0)
        begin
            c = 9'd1;
        end
        if (c > 9'(CHUNK_LIMIT))
        begin
            c = 9'(CHUNK_LIMIT);
        end
        return 8'(c - 9'd1);
    endfunction

endpackage

`default_nettype wire

[sv/pwr_ctrl.sv]
// Controller of the packet word repacker: word acceptance, end-of-packet flush and output valid.
`default_nettype none

module pwr_ctrl
    import pwr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire pwr_sts_t sts,
    output pwr_cmd_t      cmd
);

    typedef enum logic {
        S_ACCEPT,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_ACCEPT:
            begin
                in_ready   = slot_free;
                cmd.accept = in_valid && slot_free;
                cmd.emit   = cmd.accept && sts.emit_need;
                if (cmd.emit && sts.more)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                cmd.flush = 1'b1;
                cmd.emit  = slot_free;
                if (cmd.emit && !sts.more)
                begin
                    state_next = S_ACCEPT;
                end
            end
            default:
            begin
                state_next = S_ACCEPT;
            end
        endcase
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACCEPT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[sv/pwr_datapath.sv]
// Datapath of the packet word repacker: configuration, byte count, chunk tracking and output word.
`default_nettype none

module pwr_datapath
    import pwr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pwr_cmd_t    cmd,
    output pwr_sts_t         sts,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic [31:0] packet_id,
    input  wire logic [7:0]  source_port,
    input  wire logic [15:0] packet_bytes,
    input  wire logic [2:0]  packet_priority,
    input  wire logic [6:0]  in_valid_bytes,
    input  wire logic        in_pkt_end,
    input  wire logic        in_chunk_end,
    output logic [31:0]      out_packet_id,
    output logic [7:0]       out_source_port,
    output logic [15:0]      out_packet_bytes,
    output logic [2:0]       out_priority,
    output logic [15:0]      word_sequence,
    output logic             pkt_start,
    output logic             pkt_end,
    output logic             chunk_open,
    output logic             chunk_close,
    output logic [6:0]       out_valid_bytes,
    output logic             last_of_run
);

    logic [6:0]  width_cfg_reg;
    logic [5:0]  hole_cfg_reg;
    logic [8:0]  first_cfg_reg;
    logic [8:0]  later_cfg_reg;

    logic        in_packet_reg, in_packet_next;
    logic [6:0]  gathered_reg, gathered_next;
    logic        past_first_reg, past_first_next;
    logic [7:0]  word_in_chunk_reg, word_in_chunk_next;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] held_id_reg, held_id_next;
    logic [7:0]  held_port_reg, held_port_next;
    logic [15:0] held_bytes_reg, held_bytes_next;
    logic [2:0]  held_prio_reg, held_prio_next;

    logic [31:0] o_id_reg;
    logic [7:0]  o_port_reg;
    logic [15:0] o_bytes_reg;
    logic [2:0]  o_prio_reg;
    logic [15:0] o_seq_reg;
    logic        o_sop_reg, o_eop_reg, o_first_reg, o_last_reg, o_run_reg;
    logic [6:0]  o_valid_reg;

    logic [6:0]  width;
    logic        start;
    logic [6:0]  base;
    logic [7:0]  sum;
    logic [6:0]  g1;
    logic        ends_in;
    logic [6:0]  g_sel;
    logic        ends_sel;
    logic        eop_w;
    logic [31:0] id_cur;
    logic [7:0]  port_cur;
    logic [15:0] bytes_cur;
    logic [2:0]  prio_cur;
    logic [15:0] seq_cur;
    logic [7:0]  span;
    logic        w_first, w_last;
    logic        chunk_past_next;
    logic [7:0]  chunk_word_next;

    always_comb
    begin
        width = width_cfg_reg;
        if (width_cfg_reg < 7'(MIN_WIDTH_BYTES))
        begin
            width = 7'(MIN_WIDTH_BYTES);
        end
        else if (width_cfg_reg > 7'(MAX_WIDTH_BYTES))
        begin
            width = 7'(MAX_WIDTH_BYTES);
        end
    end

    always_comb
    begin
        start    = !in_packet_reg && (gathered_reg == 7'd0);
        base     = start ? 7'(hole_cfg_reg) : gathered_reg;
        sum      = {1'b0, base} + {1'b0, in_valid_bytes};
        g1       = (sum > 8'(GATHER_CAP)) ? 7'(GATHER_CAP) : sum[6:0];
        ends_in  = in_pkt_end && in_chunk_end;
        g_sel    = cmd.flush ? gathered_reg : g1;
        ends_sel = cmd.flush || ends_in;
        eop_w    = ends_sel && (g_sel <= width);

        sts.emit_need = (g1 >= width) || ends_in;
        sts.more      = ends_sel && !eop_w;

        if (!cmd.flush && start)
        begin
            id_cur    = packet_id;
            port_cur  = source_port;
            bytes_cur = packet_bytes;
            prio_cur  = packet_priority;
            seq_cur   = 16'd0;
        end
        else
        begin
            id_cur    = held_id_reg;
            port_cur  = held_port_reg;
            bytes_cur = held_bytes_reg;
            prio_cur  = held_prio_reg;
            seq_cur   = seq_reg;
        end
    end

    always_comb
    begin
        span            = past_first_reg ? chunk_span(later_cfg_reg) : chunk_span(first_cfg_reg);
        w_first         = 1'b0;
        w_last          = 1'b0;
        chunk_past_next = past_first_reg;
        chunk_word_next = word_in_chunk_reg + 8'd1;
        if (word_in_chunk_reg == 8'd0)
        begin
            w_first = 1'b1;
            if (span == 8'd0)
            begin
                w_last          = 1'b1;
                chunk_past_next = 1'b1;
                chunk_word_next = 8'd0;
            end
        end
        else if (word_in_chunk_reg == span)
        begin
            w_last          = 1'b1;
            chunk_past_next = 1'b1;
            chunk_word_next = 8'd0;
        end
    end

    always_comb
    begin
        in_packet_next     = in_packet_reg;
        gathered_next      = gathered_reg;
        past_first_next    = past_first_reg;
        word_in_chunk_next = word_in_chunk_reg;
        seq_next           = seq_reg;
        held_id_next       = held_id_reg;
        held_port_next     = held_port_reg;
        held_bytes_next    = held_bytes_reg;
        held_prio_next     = held_prio_reg;
        if (cmd.accept)
        begin
            in_packet_next  = 1'b1;
            gathered_next   = g1;
            held_id_next    = id_cur;
            held_port_next  = port_cur;
            held_bytes_next = bytes_cur;
            held_prio_next  = prio_cur;
            seq_next        = seq_cur;
        end
        if (cmd.emit)
        begin
            seq_next = seq_cur + 16'd1;
            if (eop_w)
            begin
                in_packet_next     = 1'b0;
                gathered_next      = 7'd0;
                past_first_next    = 1'b0;
                word_in_chunk_next = 8'd0;
            end
            else
            begin
                gathered_next      = (g_sel >= width) ? (g_sel - width) : 7'd0;
                past_first_next    = chunk_past_next;
                word_in_chunk_next = chunk_word_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg     <= 7'(MAX_WIDTH_BYTES);
            hole_cfg_reg      <= 6'd0;
            first_cfg_reg     <= 9'd1;
            later_cfg_reg     <= 9'd1;
            in_packet_reg     <= 1'b0;
            gathered_reg      <= 7'd0;
            past_first_reg    <= 1'b0;
            word_in_chunk_reg <= 8'd0;
            seq_reg           <= 16'd0;
            held_id_reg       <= 32'd0;
            held_port_reg     <= 8'd0;
            held_bytes_reg    <= 16'd0;
            held_prio_reg     <= 3'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_OUT_WIDTH:   width_cfg_reg <= cfg_data[6:0];
                    REG_HEADER_HOLE: hole_cfg_reg  <= cfg_data[5:0];
                    REG_FIRST_CHUNK: first_cfg_reg <= cfg_data;
                    REG_LATER_CHUNK: later_cfg_reg <= cfg_data;
                    default:         width_cfg_reg <= width_cfg_reg;
                endcase
            end
            in_packet_reg     <= in_packet_next;
            gathered_reg      <= gathered_next;
            past_first_reg    <= past_first_next;
            word_in_chunk_reg <= word_in_chunk_next;
            seq_reg           <= seq_next;
            held_id_reg       <= held_id_next;
            held_port_reg     <= held_port_next;
            held_bytes_reg    <= held_bytes_next;
            held_prio_reg     <= held_prio_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_id_reg    <= id_cur;
            o_port_reg  <= port_cur;
            o_bytes_reg <= bytes_cur;
            o_prio_reg  <= prio_cur;
            o_seq_reg   <= seq_cur;
            o_sop_reg   <= !past_first_reg;
            o_eop_reg   <= eop_w;
            o_first_reg <= w_first;
            o_last_reg  <= w_last || eop_w;
            o_valid_reg <= eop_w ? g_sel : width;
            o_run_reg   <= eop_w || !ends_sel;
        end
    end

    assign out_packet_id    = o_id_reg;
    assign out_source_port  = o_port_reg;
    assign out_packet_bytes = o_bytes_reg;
    assign out_priority     = o_prio_reg;
    assign word_sequence    = o_seq_reg;
    assign pkt_start        = o_sop_reg;
    assign pkt_end          = o_eop_reg;
    assign chunk_open       = o_first_reg;
    assign chunk_close      = o_last_reg;
    assign out_valid_bytes  = o_valid_reg;
    assign last_of_run      = o_run_reg;

endmodule

`default_nettype wire

[sv/packet_word_repacker_core.sv]
// Top level of the packet word repacker: stream ports, configuration port and unit wiring.
// A result word reaches the master side in the cycle after its last input word is taken.
// Throughput: one word per cycle unless the master side stalls or a packet end flushes.
// A packet end that yields more than one output word sends one per cycle through the single
// output register unless the master stalls, and holds the input side until the last is sent.
// Reset: asynchronous active-low rst_n clears control state and loads register defaults.
`default_nettype none

module packet_word_repacker_core
    import pwr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // packet_id, source_port, packet_bytes, packet_priority, in_valid_bytes, zero pad
    input  wire logic [71:0] s_axis_tdata,
    // in_chunk_end
    input  wire logic [0:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_packet_id, out_source_port, out_packet_bytes, out_priority, word_sequence,
    // out_valid_bytes, zero pad
    output logic [87:0]      m_axis_tdata,
    // pkt_start, chunk_open, chunk_close, last_of_run
    output logic [3:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    pwr_cmd_t    cmd;
    pwr_sts_t    sts;
    logic [31:0] o_id;
    logic [7:0]  o_port;
    logic [15:0] o_bytes;
    logic [2:0]  o_prio;
    logic [15:0] o_seq;
    logic [6:0]  o_valid;

    assign cfg_ready = 1'b1;

    pwr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pwr_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_write        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .packet_id        (s_axis_tdata[31:0]),
        .source_port      (s_axis_tdata[39:32]),
        .packet_bytes     (s_axis_tdata[55:40]),
        .packet_priority  (s_axis_tdata[58:56]),
        .in_valid_bytes   (s_axis_tdata[65:59]),
        .in_pkt_end       (s_axis_tlast),
        .in_chunk_end     (s_axis_tuser[0]),
        .out_packet_id    (o_id),
        .out_source_port  (o_port),
        .out_packet_bytes (o_bytes),
        .out_priority     (o_prio),
        .word_sequence    (o_seq),
        .pkt_start        (m_axis_tuser[0]),
        .pkt_end          (m_axis_tlast),
        .chunk_open       (m_axis_tuser[1]),
        .chunk_close      (m_axis_tuser[2]),
        .out_valid_bytes  (o_valid),
        .last_of_run      (m_axis_tuser[3])
    );

    assign m_axis_tdata = {6'd0, o_valid, o_seq, o_prio, o_bytes, o_port, o_id};

endmodule

`default_nettype wire

[sv/pwr_checker.sv]
// Port-level checks of the packet word repacker and their binding to the top level.
`default_nettype none

module pwr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [1:0]  cfg_index,
    input wire logic [8:0]  cfg_data,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [71:0] s_axis_tdata,
    input wire logic [0:0]  s_axis_tuser,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [87:0] m_axis_tdata,
    input wire logic [3:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // A stalled output word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // No input word is taken while the output register is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // The packet end word closes its chunk and its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2] && m_axis_tuser[3])
        else $error("packet end word without chunk end or run end");

    // Every word before the packet end is a full word of at least the minimum width.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[81:75] >= 7'd4)
        else $error("short word before packet end");

endmodule

bind packet_word_repacker_core pwr_checker u_pwr_checker (.*);

`default_nettype wire

[test/repack_checker.sv]
// Checker for the packet word repacker: tracks configuration, predicts result words and compares them.
`timescale 1ns / 1ps

module repack_checker
    import pwr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic [0:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [87:0] m_axis_tdata,
    input  wire logic [3:0]  m_axis_tuser,
    input  wire logic        m_axis_tlast,
    output int               fail_count,
    output int               pending_results,
    output int               words_in,
    output int               words_out
);

    localparam int MAX_RUN_WORDS = 32;

    typedef struct packed {
        logic [31:0] pkt_id;
        logic [7:0]  port;
        logic [15:0] pkt_bytes;
        logic [2:0]  prio;
        logic [15:0] seq;
        logic        sop;
        logic        eop;
        logic        first;
        logic        last;
        logic [6:0]  valid_bytes;
        logic        run_end;
    } rep_word_t;

    rep_word_t expected_words[$];

    logic [6:0]  cfg_width;
    logic [5:0]  cfg_hole;
    logic [8:0]  cfg_first;
    logic [8:0]  cfg_later;

    logic        in_pkt;
    logic [7:0]  gathered;
    logic        past_first;
    logic [7:0]  word_idx;
    logic [15:0] seq_count;
    logic [31:0] held_id;
    logic [7:0]  held_port;
    logic [15:0] held_bytes;
    logic [2:0]  held_prio;

    int          mismatch_total;
    int          in_total;
    int          out_total;
    rep_word_t   got;
    rep_word_t   want;

    function automatic logic [6:0] width_now();
        int w;
        w = cfg_width;
        if (w < MIN_WIDTH_BYTES)
        begin
            w = MIN_WIDTH_BYTES;
        end
        if (w > MAX_WIDTH_BYTES)
        begin
            w = MAX_WIDTH_BYTES;
        end
        return 7'(w);
    endfunction

    function automatic logic [7:0] chunk_last_index(input logic [8:0] words);
        int n;
        n = words;
        if (n < 1)
        begin
            n = 1;
        end
        if (n > CHUNK_LIMIT)
        begin
            n = CHUNK_LIMIT;
        end
        return 8'(n - 1);
    endfunction

    task automatic build_out_word(input logic eop, input logic [6:0] w, output rep_word_t r);
        logic [7:0] span;
        r = '0;
        r.pkt_id = held_id;
        r.port = held_port;
        r.pkt_bytes = held_bytes;
        r.prio = held_prio;
        r.seq = seq_count;
        span = chunk_last_index(cfg_later);
        if (!past_first)
        begin
            r.sop = 1'b1;
            span = chunk_last_index(cfg_first);
        end
        if (word_idx == 8'd0)
        begin
            r.first = 1'b1;
            if (span == 8'd0)
            begin
                r.last = 1'b1;
                past_first = 1'b1;
            end
            else
            begin
                word_idx = word_idx + 8'd1;
            end
        end
        else if (word_idx == span)
        begin
            r.last = 1'b1;
            past_first = 1'b1;
            word_idx = 8'd0;
        end
        else
        begin
            word_idx = word_idx + 8'd1;
        end
        if (eop)
        begin
            r.last = 1'b1;
            r.eop = 1'b1;
            r.valid_bytes = gathered[6:0];
            gathered = 8'd0;
            word_idx = 8'd0;
            past_first = 1'b0;
            in_pkt = 1'b0;
        end
        else
        begin
            r.valid_bytes = w;
            gathered = (gathered >= {1'b0, w}) ? gathered - {1'b0, w} : 8'd0;
        end
        seq_count = seq_count + 16'd1;
    endtask

    task automatic predict_repack(input logic [71:0] d, input logic eop_in, input logic chunk_end);
        logic [6:0] w;
        logic       ends;
        int         total;
        int         n;
        rep_word_t  cur;
        rep_word_t  prev;
        w = width_now();
        if (gathered == 8'd0 && !in_pkt)
        begin
            in_pkt = 1'b1;
            gathered = {2'b00, cfg_hole};
            held_id = d[31:0];
            held_port = d[39:32];
            held_bytes = d[55:40];
            held_prio = d[58:56];
            seq_count = 16'd0;
        end
        total = gathered + d[65:59];
        if (total > GATHER_CAP)
        begin
            total = GATHER_CAP;
        end
        gathered = 8'(total);
        ends = eop_in && chunk_end;
        n = 0;
        prev = '0;
        if (gathered >= {1'b0, w} || ends)
        begin
            do
            begin
                build_out_word(ends && gathered <= {1'b0, w}, w, cur);
                if (n > 0)
                begin
                    expected_words.push_back(prev);
                end
                prev = cur;
                n++;
            end
            while (ends && gathered != 8'd0 && n < MAX_RUN_WORDS);
            prev.run_end = 1'b1;
            expected_words.push_back(prev);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t ns: mismatch in %s, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            mismatch_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width = 7'd64;
            cfg_hole = 6'd0;
            cfg_first = 9'd1;
            cfg_later = 9'd1;
            in_pkt = 1'b0;
            gathered = 8'd0;
            past_first = 1'b0;
            word_idx = 8'd0;
            seq_count = 16'd0;
            held_id = 32'd0;
            held_port = 8'd0;
            held_bytes = 16'd0;
            held_prio = 3'd0;
            expected_words.delete();
            mismatch_total = 0;
            in_total = 0;
            out_total = 0;
            fail_count <= 0;
            pending_results <= 0;
            words_in <= 0;
            words_out <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (pwr_reg_t'(cfg_index))
                    REG_OUT_WIDTH:   cfg_width = cfg_data[6:0];
                    REG_HEADER_HOLE: cfg_hole = cfg_data[5:0];
                    REG_FIRST_CHUNK: cfg_first = cfg_data;
                    REG_LATER_CHUNK: cfg_later = cfg_data;
                    default:         ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_repack(s_axis_tdata, s_axis_tlast, s_axis_tuser[0]);
                in_total++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_total++;
                got.pkt_id = m_axis_tdata[31:0];
                got.port = m_axis_tdata[39:32];
                got.pkt_bytes = m_axis_tdata[55:40];
                got.prio = m_axis_tdata[58:56];
                got.seq = m_axis_tdata[74:59];
                got.valid_bytes = m_axis_tdata[81:75];
                got.sop = m_axis_tuser[0];
                got.first = m_axis_tuser[1];
                got.last = m_axis_tuser[2];
                got.run_end = m_axis_tuser[3];
                got.eop = m_axis_tlast;
                if (expected_words.size() == 0)
                begin
                    $display("%0t ns: unexpected result word, expected none, actual 0x%0h",
                             $time, got);
                    mismatch_total++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("out_packet_id", want.pkt_id, got.pkt_id);
                    check_field("out_source_port", want.port, got.port);
                    check_field("out_packet_bytes", want.pkt_bytes, got.pkt_bytes);
                    check_field("out_priority", want.prio, got.prio);
                    check_field("word_sequence", want.seq, got.seq);
                    check_field("pkt_start", want.sop, got.sop);
                    check_field("pkt_end", want.eop, got.eop);
                    check_field("chunk_open", want.first, got.first);
                    check_field("chunk_close", want.last, got.last);
                    check_field("out_valid_bytes", want.valid_bytes, got.valid_bytes);
                    check_field("last_of_run", want.run_end, got.run_end);
                end
            end
            fail_count <= mismatch_total;
            pending_results <= expected_words.size();
            words_in <= in_total;
            words_out <= out_total;
        end
    end

endmodule

[test/packet_word_repacker_core_tb.sv]
// Testbench top for the packet word repacker: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps

module packet_word_repacker_core_tb;
    import pwr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 160;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_WORDS    = 49;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int          fail_count;
    int          pending_results;
    int          words_in;
    int          words_out;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_request = 1'b0;
    int          quiet_cycles = 0;
    int          settings_used = 0;
    int          phase_count;

    packet_word_repacker_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    repack_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .words_in        (words_in),
        .words_out       (words_out)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The output side idles at random, and once holds off for a long stretch on request.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic put_reg(input pwr_reg_t idx, input logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_regs(input logic [6:0] width, input logic [5:0] hole,
                              input logic [8:0] first_words, input logic [8:0] later_words);
        put_reg(REG_OUT_WIDTH, {2'b00, width});
        put_reg(REG_HEADER_HOLE, {3'b000, hole});
        put_reg(REG_FIRST_CHUNK, first_words);
        put_reg(REG_LATER_CHUNK, later_words);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_word(input logic [31:0] id, input logic [7:0] port,
                             input logic [15:0] pkt_bytes, input logic [2:0] prio,
                             input logic [6:0] nbytes, input logic eop, input logic chunk_end);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b000000, nbytes, prio, pkt_bytes, port, id};
        s_axis_tuser <= chunk_end;
        s_axis_tlast <= eop;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_word(input logic eop, input logic chunk_end);
        send_word($urandom, 8'($urandom), 16'($urandom), 3'($urandom),
                  7'($urandom_range(0, 64)), eop, chunk_end);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed packets; interior words sometimes carry a lone end or chunk mark.
    task automatic send_packet(output int sent);
        int len;
        int k;
        int noise;
        len = $urandom_range(1, 8);
        for (k = 0; k < len - 1; k++)
        begin
            noise = $urandom_range(0, 19);
            send_random_word(noise == 0, noise == 1);
        end
        send_random_word(1'b1, 1'b1);
        sent = len;
    endtask

    function automatic logic [8:0] pick_chunk_words();
        if ($urandom_range(0, 4) == 0)
        begin
            return 9'd256;
        end
        return 9'($urandom_range(1, 6));
    endfunction

    function automatic logic [6:0] pick_width();
        case ($urandom_range(0, 3))
            0:       return 7'd4;
            1:       return 7'd64;
            default: return 7'($urandom_range(4, 64));
        endcase
    endfunction

    initial
    begin
        int sent;
        int phase_words;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_OUT_WIDTH;
        cfg_data = 9'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 72'd0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: full width, no header hole, one-word chunks.
        send_word(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 3'd7, 7'd64, 1'b0, 1'b0);
        send_word(32'h0, 8'h0, 16'h0, 3'd0, 7'd10, 1'b1, 1'b0);
        send_word(32'h0, 8'h0, 16'h0, 3'd0, 7'd0, 1'b0, 1'b1);
        send_word(32'h0, 8'h0, 16'h0, 3'd0, 7'd0, 1'b1, 1'b1);
        send_word(32'h1234_5678, 8'h5A, 16'h0100, 3'd3, 7'd0, 1'b1, 1'b1);
        send_word(32'hA5A5_5A5A, 8'hA5, 16'h8000, 3'd4, 7'd64, 1'b1, 1'b1);
        drain_results();

        // Narrowest width with the largest hole saturates the byte count and flushes 32 words.
        write_regs(7'd4, 6'd63, 9'd256, 9'd2);
        send_word(32'h0000_0000, 8'h00, 16'h0000, 3'd0, 7'd64, 1'b1, 1'b1);
        send_word(32'h0000_0001, 8'h01, 16'h0001, 3'd1, 7'd1, 1'b0, 1'b0);
        send_word(32'h0000_0002, 8'h02, 16'h0002, 3'd2, 7'd64, 1'b0, 1'b0);
        send_word(32'h0000_0003, 8'h03, 16'h0003, 3'd5, 7'd64, 1'b1, 1'b1);
        drain_results();

        // Width below its range, chunk size zero and chunk size above the limit.
        write_regs(7'd2, 6'd0, 9'd0, 9'd300);
        send_random_word(1'b0, 1'b0);
        send_word(32'hDEAD_BEEF, 8'h11, 16'h0040, 3'd6, 7'd4, 1'b0, 1'b0);
        send_word(32'h0BAD_F00D, 8'h22, 16'h0041, 3'd0, 7'd64, 1'b0, 1'b1);
        send_word(32'hCAFE_0000, 8'h33, 16'h0042, 3'd1, 7'd7, 1'b1, 1'b1);
        drain_results();

        // Width above its range with the largest chunk field value.
        write_regs(7'd127, 6'd5, 9'd3, 9'd511);
        send_random_word(1'b0, 1'b0);
        send_random_word(1'b0, 1'b0);
        send_random_word(1'b0, 1'b0);
        send_word(32'h7FFF_FFFF, 8'h80, 16'h7FFF, 3'd7, 7'd64, 1'b0, 1'b0);
        send_word(32'h0, 8'h0, 16'h0, 3'd0, 7'd0, 1'b1, 1'b1);
        drain_results();

        for (phase_count = 0; phase_count < 6; phase_count++)
        begin
            if (phase_count < 2)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 54;
            end
            else if (phase_count < 4)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_regs(pick_width(), 6'($urandom_range(0, 63)), pick_chunk_words(),
                       pick_chunk_words());
            if (phase_count == 4)
            begin
                hold_request = 1'b1;
            end
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                send_packet(sent);
                phase_words += sent;
            end
            drain_results();
        end

        $display("Summary: %0d input words and %0d result words checked over %0d settings,",
                 words_in, words_out, settings_used);
        $display("with idling on either side, a phase without idling and one long output stall.");
        if (fail_count == 0 && pending_results == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
